// ===== hw/rtl/bfa_pkg.sv =====
// shared types, codes and constants of the bitmap first-free allocator
package bfa_pkg;

    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;
    localparam int LIMIT_W   = 13;
    localparam int INDEX_W   = 12;
    localparam int STATUS_W  = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_ALLOC_WR,
        S_FREE_RD,
        S_FREE_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic req_ready;
        logic clr_step;
        logic take_req;
        logic scan_step;
        logic free_rd;
        logic alloc_wr;
        logic free_wr;
        logic set_full;
        logic set_range;
        logic load_res;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic free_ok;
        logic scan_hit;
        logic scan_miss;
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/bfa_if.sv =====
// request, response and configuration channel interfaces
interface bfa_req_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [bfa_pkg::INDEX_W-1:0] unit_index;

    modport source (output valid, output op, output unit_index, input ready);
    modport sink   (input valid, input op, input unit_index, output ready);
endinterface

interface bfa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bfa_pkg::STATUS_W-1:0] status;
    logic [bfa_pkg::INDEX_W-1:0]  granted_index;

    modport source (output valid, output status, output granted_index, input ready);
    modport sink   (input valid, input status, input granted_index, output ready);
endinterface

interface bfa_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [bfa_pkg::LIMIT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/bfa_ctrl.sv =====
// allocator control state machine
module bfa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  logic          i_req_op,
    input  bfa_pkg::t_sts i_sts,
    output bfa_pkg::t_cmd o_cmd
);
    import bfa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req_valid) n_state = (i_req_op == OP_FREE) ? S_FREE_RD : S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_hit) begin
                    n_state = S_ALLOC_WR;
                end else if (i_sts.scan_miss) begin
                    n_state = S_DONE;
                end
            end
            S_ALLOC_WR: n_state = S_DONE;
            S_FREE_RD: begin
                n_state = i_sts.free_ok ? S_FREE_WR : S_DONE;
            end
            S_FREE_WR: n_state = S_DONE;
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_CLEAR: o_cmd.clr_step = 1'b1;
            S_IDLE: begin
                o_cmd.req_ready = 1'b1;
                o_cmd.take_req  = i_req_valid;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                o_cmd.set_full  = i_sts.scan_miss;
            end
            S_ALLOC_WR: o_cmd.alloc_wr = 1'b1;
            S_FREE_RD: begin
                o_cmd.free_rd   = i_sts.free_ok;
                o_cmd.set_range = !i_sts.free_ok;
            end
            S_FREE_WR: o_cmd.free_wr = 1'b1;
            S_DONE: o_cmd.load_res = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== hw/rtl/bfa_datapath.sv =====
// bitmap memory, scan pipeline, limit register and response register
module bfa_datapath #(
    parameter int MAX_UNITS = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bfa_pkg::t_cmd                i_cmd,
    output bfa_pkg::t_sts                o_sts,
    input  logic [bfa_pkg::INDEX_W-1:0]  i_req_unit_index,
    input  logic                         i_cfg_valid,
    input  logic [bfa_pkg::LIMIT_W-1:0]  i_cfg_data,
    input  logic                         i_rsp_ready,
    output logic                         o_rsp_valid,
    output logic [bfa_pkg::STATUS_W-1:0] o_rsp_status,
    output logic [bfa_pkg::INDEX_W-1:0]  o_rsp_granted_index
);
    import bfa_pkg::*;

    localparam int NUM_WORDS = (MAX_UNITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int UNIT_W    = WA_W + BIT_W;
    localparam int CW        = ((UNIT_W > LIMIT_W) ? UNIT_W : LIMIT_W) + 1;

    localparam logic [WA_W-1:0] LAST_WORD = WA_W'(NUM_WORDS - 1);
    localparam logic [CW-1:0]   UNITS_C   = CW'(MAX_UNITS);

    logic [WORD_BITS-1:0] r_bitmap [NUM_WORDS];
    logic [WORD_BITS-1:0] r_rd_data;

    logic [LIMIT_W-1:0]   r_limit;
    logic [WA_W-1:0]      r_clr_cnt;
    logic [INDEX_W-1:0]   r_idx;
    logic [WA_W-1:0]      r_scan_cnt;
    logic                 r_issued_all;
    logic                 r_dv;
    logic [WA_W-1:0]      r_dv_addr;
    logic [WORD_BITS-1:0] r_hit_word;
    logic [WA_W-1:0]      r_hit_addr;
    logic [BIT_W-1:0]     r_hit_bit;
    logic [STATUS_W-1:0]  r_status;
    logic [INDEX_W-1:0]   r_grant;
    logic                 r_o_valid;
    logic [STATUS_W-1:0]  r_o_status;
    logic [INDEX_W-1:0]   r_o_grant;

    logic                 scan_issue;
    logic                 rd_en;
    logic [WA_W-1:0]      rd_addr;
    logic                 wr_en;
    logic [WA_W-1:0]      wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic [CW-1:0]        idx_ext;
    logic [CW-1:0]        unit_ext;
    logic [CW-1:0]        limit_ext;
    logic [WA_W-1:0]      idx_word;
    logic                 unit_ok;
    logic                 word_full;

    function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] b;
        b = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (!w[k]) b = BIT_W'(k);
        end
        return b;
    endfunction

    assign idx_ext   = CW'(r_idx);
    assign unit_ext  = CW'({r_hit_addr, r_hit_bit});
    assign limit_ext = CW'(r_limit);
    assign idx_word  = idx_ext[WA_W+BIT_W-1:BIT_W];
    assign unit_ok   = (unit_ext < limit_ext) && (unit_ext < UNITS_C);
    assign word_full = &r_rd_data;
    assign scan_issue = i_cmd.scan_step && !r_issued_all;

    assign o_sts.clr_last  = (r_clr_cnt == LAST_WORD);
    assign o_sts.free_ok   = (idx_ext < limit_ext) && (idx_ext < UNITS_C);
    assign o_sts.scan_hit  = r_dv && !word_full;
    assign o_sts.scan_miss = r_dv && word_full && (r_dv_addr == LAST_WORD);
    assign o_sts.out_free  = !r_o_valid || i_rsp_ready;

    always_comb begin
        rd_en   = scan_issue || i_cmd.free_rd;
        rd_addr = i_cmd.free_rd ? idx_word : r_scan_cnt;
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_clr_cnt;
        wr_data = '0;
        if (i_cmd.clr_step) begin
            wr_en = 1'b1;
        end else if (i_cmd.alloc_wr) begin
            wr_en   = unit_ok;
            wr_addr = r_hit_addr;
            wr_data = r_hit_word | (WORD_BITS'(1) << r_hit_bit);
        end else if (i_cmd.free_wr) begin
            wr_en   = 1'b1;
            wr_addr = idx_word;
            wr_data = r_rd_data & ~(WORD_BITS'(1) << r_idx[BIT_W-1:0]);
        end
    end

    // bitmap store
    always_ff @(posedge i_clk) begin
        if (wr_en) r_bitmap[wr_addr] <= wr_data;
        if (rd_en) r_rd_data <= r_bitmap[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit      <= LIMIT_RESET;
            r_clr_cnt    <= '0;
            r_scan_cnt   <= '0;
            r_issued_all <= 1'b0;
            r_dv         <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) r_limit <= i_cfg_data;
            if (i_cmd.clr_step && (r_clr_cnt != LAST_WORD)) r_clr_cnt <= r_clr_cnt + 1'b1;
            if (i_cmd.take_req) begin
                r_scan_cnt   <= '0;
                r_issued_all <= 1'b0;
            end else if (scan_issue) begin
                r_scan_cnt   <= r_scan_cnt + 1'b1;
                r_issued_all <= (r_scan_cnt == LAST_WORD);
            end
            r_dv <= scan_issue;
            if (i_cmd.load_res) begin
                r_o_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_req) r_idx <= i_req_unit_index;
        if (scan_issue) r_dv_addr <= r_scan_cnt;
        if (i_cmd.scan_step && o_sts.scan_hit) begin
            r_hit_word <= r_rd_data;
            r_hit_addr <= r_dv_addr;
            r_hit_bit  <= lowest_zero(r_rd_data);
        end
        if (i_cmd.alloc_wr) begin
            r_status <= unit_ok ? ST_OK : ST_FULL;
            r_grant  <= unit_ok ? unit_ext[INDEX_W-1:0] : '0;
        end else if (i_cmd.free_wr) begin
            r_status <= ST_OK;
            r_grant  <= '0;
        end else if (i_cmd.set_full) begin
            r_status <= ST_FULL;
            r_grant  <= '0;
        end else if (i_cmd.set_range) begin
            r_status <= ST_RANGE;
            r_grant  <= '0;
        end
        if (i_cmd.load_res) begin
            r_o_status <= r_status;
            r_o_grant  <= r_grant;
        end
    end

    assign o_rsp_valid         = r_o_valid;
    assign o_rsp_status        = r_o_status;
    assign o_rsp_granted_index = r_o_grant;

endmodule

// ===== hw/rtl/bitmap_first_free_allocator_core.sv =====
// Bitmap first-free allocator: one bit per unit in MAX_UNITS/32 words of a single-port-read,
// single-port-write memory. After reset a clearing pass writes one word per cycle, so requests
// are held off until the pass has cleared the last word; the limit register can be
// written at any time that the block is idle, including during that pass. One request is
// worked at a time. An allocate reads the bitmap one word per cycle from word 0 up and stops
// at the first word with a clear bit: the bit is set in the allocate-write state, and the
// response is loaded into the response register from the done state once that is free. A free
// reads and rewrites one word; an out-of-range free does neither and reports a range error.
// The response register lets the next request be taken while a response still waits.
module bitmap_first_free_allocator_core #(
    parameter int MAX_UNITS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bfa_req_if.sink     i_req,
    bfa_rsp_if.source   o_rsp,
    bfa_cfg_if.sink     i_cfg
);
    import bfa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign i_req.ready = cmd.req_ready;
    assign i_cfg.ready = 1'b1;

    bfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_op    (i_req.op),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bfa_datapath #(
        .MAX_UNITS (MAX_UNITS)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_req_unit_index    (i_req.unit_index),
        .i_cfg_valid         (i_cfg.valid),
        .i_cfg_data          (i_cfg.data),
        .i_rsp_ready         (o_rsp.ready),
        .o_rsp_valid         (o_rsp.valid),
        .o_rsp_status        (o_rsp.status),
        .o_rsp_granted_index (o_rsp.granted_index)
    );

endmodule

// ===== hw/rtl/bfa_checker.sv =====
// port-level checks of the allocator and their binding to the top level
module bfa_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_req_valid,
    input logic                         i_req_ready,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic [bfa_pkg::STATUS_W-1:0] i_rsp_status,
    input logic [bfa_pkg::INDEX_W-1:0]  i_rsp_granted_index
);
    import bfa_pkg::*;

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> $stable(i_rsp_status) && $stable(i_rsp_granted_index))
        else $error("response changed while stalled");

    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status != ST_OK) |-> (i_rsp_granted_index == '0))
        else $error("granted index set on a failed request");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while another is in progress");

endmodule

bind bitmap_first_free_allocator_core bfa_checker u_bfa_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_req_valid         (i_req.valid),
    .i_req_ready         (i_req.ready),
    .i_rsp_valid         (o_rsp.valid),
    .i_rsp_ready         (o_rsp.ready),
    .i_rsp_status        (o_rsp.status),
    .i_rsp_granted_index (o_rsp.granted_index)
);

// ===== dv/tb_top.sv =====
// self-checking testbench for the bitmap first-free allocator core
`timescale 1ns / 1ps

module tb_top;
    import bfa_pkg::*;

    localparam int TB_UNITS    = 4096;
    localparam int NUM_WORDS   = TB_UNITS / WORD_BITS;
    localparam int CYCLE_LIMIT = 4_000_000;

    typedef struct packed {
        t_status              status;
        logic [INDEX_W-1:0]   granted;
    } t_alloc_result;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic                 op;
        logic [LIMIT_W-1:0]   value;
        logic                 typed;
        t_status              status;
        logic [INDEX_W-1:0]   granted;
    } t_row;

    localparam t_alloc_result NO_TYPED = '{ST_OK, 12'd0};

    // value is the unit index for a request, the new limit for a register write
    localparam t_row DIRECTED [23] = '{
        '{ROW_CFG, OP_ALLOC, 13'd4096, 1'b0, ST_OK,    12'd0},
        '{ROW_REQ, OP_ALLOC, 13'd0,    1'b1, ST_OK,    12'd0},
        '{ROW_REQ, OP_ALLOC, 13'd4095, 1'b1, ST_OK,    12'd1},
        '{ROW_REQ, OP_ALLOC, 13'd0,    1'b1, ST_OK,    12'd2},
        '{ROW_REQ, OP_FREE,  13'd1,    1'b1, ST_OK,    12'd0},
        '{ROW_REQ, OP_ALLOC, 13'd2730, 1'b0, ST_OK,    12'd0},
        '{ROW_REQ, OP_FREE,  13'd5,    1'b1, ST_OK,    12'd0},
        '{ROW_REQ, OP_FREE,  13'd4095, 1'b1, ST_OK,    12'd0},
        '{ROW_CFG, OP_ALLOC, 13'd3,    1'b0, ST_OK,    12'd0},
        '{ROW_REQ, OP_ALLOC, 13'd0,    1'b1, ST_FULL,  12'd0},
        '{ROW_REQ, OP_FREE,  13'd3,    1'b1, ST_RANGE, 12'd0},
        '{ROW_REQ, OP_FREE,  13'd4095, 1'b1, ST_RANGE, 12'd0},
        '{ROW_REQ, OP_FREE,  13'd2,    1'b0, ST_OK,    12'd0},
        '{ROW_REQ, OP_ALLOC, 13'd1365, 1'b0, ST_OK,    12'd0},
        '{ROW_CFG, OP_ALLOC, 13'd0,    1'b0, ST_OK,    12'd0},
        '{ROW_REQ, OP_ALLOC, 13'd0,    1'b1, ST_FULL,  12'd0},
        '{ROW_REQ, OP_FREE,  13'd0,    1'b1, ST_RANGE, 12'd0},
        '{ROW_CFG, OP_ALLOC, 13'd8191, 1'b0, ST_OK,    12'd0},
        '{ROW_REQ, OP_ALLOC, 13'd0,    1'b0, ST_OK,    12'd0},
        '{ROW_REQ, OP_FREE,  13'd4095, 1'b1, ST_OK,    12'd0},
        '{ROW_CFG, OP_ALLOC, 13'd4096, 1'b0, ST_OK,    12'd0},
        '{ROW_REQ, OP_FREE,  13'd0,    1'b1, ST_OK,    12'd0},
        '{ROW_REQ, OP_ALLOC, 13'd0,    1'b1, ST_OK,    12'd0}
    };

    logic clk;
    logic rst_n;
    bit   idle_on;

    logic [WORD_BITS-1:0] unit_map [NUM_WORDS];
    logic [LIMIT_W-1:0]   limit_copy;
    t_alloc_result        pending_results [$];
    t_alloc_result        last_prediction;
    logic [INDEX_W-1:0]   live_units [$];

    int request_count;
    int checked_count;
    int limit_writes;
    int mismatch_count;
    int cycle_count;

    bfa_req_if req_ch ();
    bfa_rsp_if rsp_ch ();
    bfa_cfg_if cfg_ch ();

    bitmap_first_free_allocator_core #(
        .MAX_UNITS (TB_UNITS)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("end of test: mismatches");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // first-fit allocate or range-checked free on the local bitmap copy
    function automatic t_alloc_result predict_alloc(input logic op, input logic [INDEX_W-1:0] idx);
        t_alloc_result res;
        int bound;
        int unit;
        res   = NO_TYPED;
        unit  = -1;
        bound = (int'(limit_copy) > TB_UNITS) ? TB_UNITS : int'(limit_copy);
        if (op == OP_ALLOC) begin
            for (int w = 0; w < NUM_WORDS && unit < 0; w++) begin
                if (unit_map[w] != '1) begin
                    for (int k = WORD_BITS - 1; k >= 0; k--) begin
                        if (!unit_map[w][k]) begin
                            unit = w * WORD_BITS + k;
                        end
                    end
                end
            end
            if (unit >= 0 && unit < bound) begin
                unit_map[unit / WORD_BITS][unit % WORD_BITS] = 1'b1;
                res.granted = unit[INDEX_W-1:0];
            end else begin
                res.status = ST_FULL;
            end
        end else if (int'(idx) >= bound) begin
            res.status = ST_RANGE;
        end else begin
            unit_map[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
        end
        return res;
    endfunction

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic send_req(input logic op, input logic [INDEX_W-1:0] idx,
                            input logic typed, input t_alloc_result typed_res);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.op         <= op;
        req_ch.unit_index <= idx;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        request_count++;
        last_prediction = predict_alloc(op, idx);
        if (op == OP_ALLOC && last_prediction.status == ST_OK) begin
            live_units.push_back(last_prediction.granted);
        end
        pending_results.push_back(typed ? typed_res : last_prediction);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] lim);
        req_ch.valid <= 1'b0;
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= lim;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        limit_copy = lim;
        limit_writes++;
    endtask

    task automatic free_live_unit();
        int pick;
        logic [INDEX_W-1:0] idx;
        pick = $urandom_range(0, live_units.size() - 1);
        idx  = live_units[pick];
        live_units.delete(pick);
        send_req(OP_FREE, idx, 1'b0, NO_TYPED);
    endtask

    task automatic random_request();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            send_req(OP_ALLOC, INDEX_W'($urandom), 1'b0, NO_TYPED);
        end else if (roll < 85 && live_units.size() > 0) begin
            free_live_unit();
        end else begin
            send_req(OP_FREE, INDEX_W'($urandom), 1'b0, NO_TYPED);
        end
    endtask

    initial begin : rsp_backpressure
        int hold;
        hold = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold > 0) begin
                hold--;
                rsp_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                hold = $urandom_range(1, 11) - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin : rsp_monitor
        t_alloc_result want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected response status %0d index %0d",
                                          rsp_ch.status, rsp_ch.granted_index));
            end else begin
                want = pending_results.pop_front();
                checked_count++;
                if (rsp_ch.status !== want.status) begin
                    report_mismatch($sformatf("response %0d status %0d, want %0d",
                                              checked_count, rsp_ch.status, want.status));
                end
                if (rsp_ch.granted_index !== want.granted) begin
                    report_mismatch($sformatf("response %0d index %0d, want %0d",
                                              checked_count, rsp_ch.granted_index,
                                              want.granted));
                end
            end
        end
    end

    initial begin : stimulus
        t_alloc_result typed_res;
        logic [LIMIT_W-1:0] lim;
        foreach (unit_map[w]) unit_map[w] = '0;
        limit_copy        = LIMIT_RESET;
        idle_on           = 1'b1;
        request_count     = 0;
        checked_count     = 0;
        limit_writes      = 0;
        mismatch_count    = 0;
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.op         <= OP_ALLOC;
        req_ch.unit_index <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.data       <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == ROW_CFG) begin
                write_limit(DIRECTED[i].value);
            end else begin
                typed_res = '{DIRECTED[i].status, DIRECTED[i].granted};
                send_req(DIRECTED[i].op, DIRECTED[i].value[INDEX_W-1:0],
                         DIRECTED[i].typed, typed_res);
            end
        end

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0, 8: lim = 13'd4096;
                1, 9: lim = LIMIT_W'($urandom_range(0, 8191));
                2: lim = LIMIT_W'($urandom_range(1, 64));
                3: lim = 13'd8191;
                4: lim = 13'd0;
                5: lim = LIMIT_W'($urandom_range(0, 4096));
                6: lim = LIMIT_W'($urandom_range(4097, 8191));
                default: lim = LIMIT_W'($urandom_range(65, 400));
            endcase
            write_limit(lim);
            idle_on = (ph % 4 != 3);
            repeat ((ph == 4) ? 25 : 50) random_request();
        end

        // fill every unit below a small limit, then churn by freeing and reallocating units
        idle_on = 1'b0;
        write_limit(13'd300);
        do begin
            send_req(OP_ALLOC, INDEX_W'($urandom), 1'b0, NO_TYPED);
        end while (last_prediction.status == ST_OK);
        repeat (40) begin
            free_live_unit();
            send_req(OP_ALLOC, INDEX_W'($urandom), 1'b0, NO_TYPED);
        end
        send_req(OP_ALLOC, INDEX_W'($urandom), 1'b0, NO_TYPED);

        req_ch.valid <= 1'b0;
        wait_drained();
        repeat (200) @(posedge clk);
        $display("%0d requests over %0d limit settings, %0d responses checked",
                 request_count, limit_writes, checked_count);
        $display("map filled below a small limit and churned, %0d mismatches", mismatch_count);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/bfa_pkg.sv
hw/rtl/bfa_if.sv
hw/rtl/bfa_ctrl.sv
hw/rtl/bfa_datapath.sv
hw/rtl/bitmap_first_free_allocator_core.sv
hw/rtl/bfa_checker.sv
dv/tb_top.sv
